// ===== sv/multi_channel_ring_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// Multi-channel ring buffer assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_RING_BUFFER_DEFINES_SVH
`define MULTI_CHANNEL_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off while in reset
`define MCRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ring buffer check failed");

// Next-cycle implication, sampled on clk_i, held off while in reset
`define MCRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ring buffer check failed");

`endif

// ===== sv/mcrb_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-channel ring buffer package
// Operation, status and fill codes, result word and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrb_pkg;

  localparam int DATA_W = 64;
  localparam int NBYTES = DATA_W / 8;
  localparam int SLOT_W = 4;
  localparam int SC_W   = 5;
  localparam int EB_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES = 1'b1;

  // Reset values of the configuration registers
  localparam logic [SC_W-1:0] SLOT_COUNT_RST = 5'd16;
  localparam logic [EB_W-1:0] ELEM_BYTES_RST = 4'd1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FIND  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_FULL_REFUSED  = 2'd1,
    ST_EMPTY_REFUSED = 2'd2,
    ST_NOT_FOUND     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FILL_EMPTY   = 2'd0,
    FILL_PARTIAL = 2'd1,
    FILL_FULL    = 2'd2
  } fill_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_SCAN = 2'd2,
    S_HOLD = 2'd3
  } state_e;

  typedef struct packed {
    status_e           code;
    logic [DATA_W-1:0] rdata;
    logic [SLOT_W-1:0] slot;
    fill_e             fill;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/multi_channel_ring_buffer.sv =====
// Timing: write, refused or absent-channel words load the output register directly; a read
//   goes through the registered slot memory read first; a find reads one slot per examined slot.
// Throughput: writes and refused words 1 per cycle while the output is not stalled; a read or
//   a find stalls the input until its result is finished, as the slot memory has a single read port.
// Reset: all indices zero, all channels empty, slot count 16, element length 1 byte;
//   the slot memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Multi-channel ring buffer
// Independent rings per channel sharing one slot memory; each word is a
// write, a read, a find of the first matching element or a no-op status query.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_ring_buffer
  import mcrb_pkg::*;
#(
  parameter int CHANNELS   = 4,
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input words
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [1:0]            channel_i,
  input  wire logic [DATA_W-1:0]     data_i,
  // Result words
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 status_code_o,
  output logic [DATA_W-1:0]          read_data_o,
  output logic [SLOT_W-1:0]          found_slot_o,
  output logic [1:0]                 fill_state_o
);

  localparam int IDX_W     = $clog2(DEPTH);
  localparam int NX_W      = IDX_W + 1;
  localparam int EW        = (NX_W > SC_W) ? NX_W : SC_W;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRIES   = CHANNELS * DEPTH;
  localparam int AW        = $clog2(ENTRIES);
  localparam int MAX_B_RAW = ELEM_WIDTH / 8;
  localparam int MAX_B     = (MAX_B_RAW < 1) ? 1 : ((MAX_B_RAW > NBYTES) ? NBYTES : MAX_B_RAW);

  // Configuration registers
  logic [SC_W-1:0] slot_count_q;
  logic [EB_W-1:0] elem_bytes_q;

  // Control
  state_e  state_q, state_d;
  result_t res_q, res_d;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;

  // Find scan
  logic [DATA_W-1:0] target_q, target_d;
  logic [AW-1:0]     base_q, base_d;
  logic [IDX_W-1:0]  wix_q, wix_d;
  logic [IDX_W-1:0]  scan_p_q, scan_p_d;
  logic [IDX_W-1:0]  scan_n_q, scan_n_d;
  logic [IDX_W-1:0]  cand_q, cand_d;
  logic              cand_last_q, cand_last_d;

  // Datapath nets
  logic [NX_W-1:0]       eff_slots;
  logic [DATA_W-1:0]     mask;
  logic [DATA_W-1:0]     data_m;
  logic [DATA_W-1:0]     rd_ext;
  logic [CH_W-1:0]       ch_sel;
  logic                  ch_ok;
  kind_e                 kind;
  logic [AW-1:0]         base;
  logic [IDX_W-1:0]      cur_widx, cur_ridx;
  fill_e                 cur_fill;
  logic                  upd_en;
  logic [IDX_W-1:0]      upd_widx, upd_ridx;
  fill_e                 upd_fill;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;
  logic                  in_acc;
  logic                  can_load;
  logic                  fin_vld;
  result_t               fin_res;
  logic                  go_read, go_scan;
  logic                  hit;

  // Step an index, wrapping at the live slot count
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [NX_W-1:0]  eff);
    logic [NX_W-1:0] nx;
    nx = {1'b0, idx} + NX_W'(1);
    if (nx >= eff) begin
      nx = '0;
    end
    return nx[IDX_W-1:0];
  endfunction

  // Byte mask for the live element length
  function automatic logic [DATA_W-1:0] byte_mask(input logic [EB_W-1:0] eb);
    logic [EB_W-1:0]   b;
    logic [DATA_W-1:0] m;
    b = eb;
    if (b == '0) begin
      b = EB_W'(1);
    end
    if (b > EB_W'(MAX_B)) begin
      b = EB_W'(MAX_B);
    end
    for (int i = 0; i < NBYTES; i++) begin
      m[i*8 +: 8] = (EB_W'(i) < b) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Clamp the slot count to between 2 and the ring depth
  always_comb begin
    logic [EW-1:0] sc;
    sc = EW'(slot_count_q);
    if (sc < EW'(2)) begin
      sc = EW'(2);
    end else if (sc > EW'(DEPTH)) begin
      sc = EW'(DEPTH);
    end
    eff_slots = NX_W'(sc);
  end

  assign mask     = byte_mask(elem_bytes_q);
  assign data_m   = data_i & mask;
  assign rd_ext   = DATA_W'(mem_rdata) & mask;
  assign ch_sel   = CH_W'(channel_i);
  assign ch_ok    = (int'(channel_i) < CHANNELS);
  assign kind     = kind_e'(kind_i);
  assign base     = AW'(ch_sel) * AW'(DEPTH);
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign can_load = !out_valid_q || !out_stall_i;
  assign hit      = (rd_ext == target_q);

  // Configuration writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
      elem_bytes_q <= ELEM_BYTES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOT_COUNT: slot_count_q <= cfg_data_i;
        CFG_ELEM_BYTES: elem_bytes_q <= cfg_data_i[EB_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel indices and status
  mcrb_chan_state #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W),
    .CH_W     (CH_W)
  ) u_chan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ch_i       (ch_sel),
    .upd_en_i   (upd_en),
    .upd_widx_i (upd_widx),
    .upd_ridx_i (upd_ridx),
    .upd_fill_i (upd_fill),
    .widx_o     (cur_widx),
    .ridx_o     (cur_ridx),
    .fill_o     (cur_fill)
  );

  // Shared slot store
  mcrb_slot_mem #(
    .ENTRIES (ENTRIES),
    .WIDTH   (ELEM_WIDTH),
    .AW      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (data_m[ELEM_WIDTH-1:0]),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Decode words, drive memory and channel updates, form results
  always_comb begin
    logic [IDX_W-1:0] nidx;
    nidx        = '0;
    mem_we      = 1'b0;
    mem_waddr   = base + AW'(cur_widx);
    mem_re      = 1'b0;
    mem_raddr   = base + AW'(cur_ridx);
    upd_en      = 1'b0;
    upd_widx    = cur_widx;
    upd_ridx    = cur_ridx;
    upd_fill    = cur_fill;
    fin_vld     = 1'b0;
    fin_res     = '{code: ST_OK, rdata: '0, slot: '0, fill: FILL_EMPTY};
    go_read     = 1'b0;
    go_scan     = 1'b0;
    res_d       = res_q;
    target_d    = target_q;
    base_d      = base_q;
    wix_d       = wix_q;
    scan_p_d    = scan_p_q;
    scan_n_d    = scan_n_q;
    cand_d      = cand_q;
    cand_last_d = cand_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!ch_ok) begin
            // Absent channel: refuse by kind, nothing changes
            fin_vld = 1'b1;
            case (kind)
              KIND_WRITE: fin_res.code = ST_FULL_REFUSED;
              KIND_READ:  fin_res.code = ST_EMPTY_REFUSED;
              KIND_FIND:  fin_res.code = ST_NOT_FOUND;
              default:    fin_res.code = ST_OK;
            endcase
          end else begin
            case (kind)
              KIND_WRITE: begin
                fin_vld = 1'b1;
                if (cur_fill == FILL_FULL) begin
                  fin_res.code = ST_FULL_REFUSED;
                  fin_res.fill = FILL_FULL;
                end else begin
                  nidx         = advance(cur_widx, eff_slots);
                  mem_we       = 1'b1;
                  upd_en       = 1'b1;
                  upd_widx     = nidx;
                  upd_fill     = (nidx == cur_ridx) ? FILL_FULL : FILL_PARTIAL;
                  fin_res.fill = upd_fill;
                end
              end
              KIND_READ: begin
                if (cur_fill == FILL_EMPTY) begin
                  fin_vld      = 1'b1;
                  fin_res.code = ST_EMPTY_REFUSED;
                end else begin
                  nidx     = advance(cur_ridx, eff_slots);
                  mem_re   = 1'b1;
                  upd_en   = 1'b1;
                  upd_ridx = nidx;
                  upd_fill = (nidx == cur_widx) ? FILL_EMPTY : FILL_PARTIAL;
                  go_read  = 1'b1;
                  res_d    = '{code: ST_OK, rdata: '0, slot: '0, fill: upd_fill};
                end
              end
              KIND_FIND: begin
                if (cur_fill == FILL_EMPTY) begin
                  fin_vld      = 1'b1;
                  fin_res.code = ST_NOT_FOUND;
                end else begin
                  // Fetch the oldest slot and line up the next one
                  nidx        = advance(cur_ridx, eff_slots);
                  mem_re      = 1'b1;
                  go_scan     = 1'b1;
                  res_d       = '{code: ST_OK, rdata: '0, slot: '0, fill: cur_fill};
                  target_d    = data_m;
                  base_d      = base;
                  wix_d       = cur_widx;
                  cand_d      = cur_ridx;
                  cand_last_d = (nidx == cur_widx) || (DEPTH == 1);
                  scan_p_d    = nidx;
                  scan_n_d    = IDX_W'(1);
                end
              end
              default: begin
                fin_vld      = 1'b1;
                fin_res.fill = cur_fill;
              end
            endcase
          end
        end
      end
      S_READ: begin
        fin_vld       = 1'b1;
        fin_res       = res_q;
        fin_res.rdata = rd_ext;
      end
      S_SCAN: begin
        // Compare the fetched slot, fetch the next one meanwhile
        mem_re    = 1'b1;
        mem_raddr = base_q + AW'(scan_p_q);
        fin_res   = res_q;
        if (hit) begin
          fin_vld      = 1'b1;
          fin_res.slot = SLOT_W'(cand_q);
        end else if (cand_last_q) begin
          fin_vld      = 1'b1;
          fin_res.code = ST_NOT_FOUND;
        end else begin
          nidx        = advance(scan_p_q, eff_slots);
          cand_d      = scan_p_q;
          cand_last_d = (nidx == wix_q) || (scan_n_q == IDX_W'(DEPTH - 1));
          scan_p_d    = nidx;
          scan_n_d    = scan_n_q + IDX_W'(1);
        end
      end
      S_HOLD: begin
        fin_vld = 1'b1;
        fin_res = res_q;
      end
      default: ;
    endcase

    // Park a finished result while the output register is still occupied
    if (fin_vld && !can_load) begin
      res_d = fin_res;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_read) begin
          state_d = S_READ;
        end else if (go_scan) begin
          state_d = S_SCAN;
        end else if (fin_vld && !can_load) begin
          state_d = S_HOLD;
        end
      end
      S_READ, S_SCAN, S_HOLD: begin
        if (fin_vld) begin
          state_d = can_load ? S_IDLE : S_HOLD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: load a finished result, drop a taken one
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (fin_vld && can_load) begin
      out_valid_d = 1'b1;
      out_d       = fin_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    out_q       <= out_d;
    target_q    <= target_d;
    base_q      <= base_d;
    wix_q       <= wix_d;
    scan_p_q    <= scan_p_d;
    scan_n_q    <= scan_n_d;
    cand_q      <= cand_d;
    cand_last_q <= cand_last_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_code_o = out_q.code;
  assign read_data_o   = out_q.rdata;
  assign found_slot_o  = out_q.slot;
  assign fill_state_o  = out_q.fill;

endmodule

`default_nettype wire

// ===== sv/mcrb_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Slot memory
// Simple dual-port synchronous RAM holding every channel's slots,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrb_slot_mem #(
  parameter int ENTRIES = 64,
  parameter int WIDTH   = 64,
  parameter int AW      = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [ENTRIES];

  // Store a word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Fetch a word into the registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mcrb_chan_state.sv =====
// ----------------------------------------------------------------------------
// Channel state
// Write index, read index and fill status for each channel, looked up
// and updated through the selected channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrb_chan_state
  import mcrb_pkg::*;
#(
  parameter int CHANNELS = 4,
  parameter int IDX_W    = 4,
  parameter int CH_W     = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CH_W-1:0]  ch_i,
  input  wire logic             upd_en_i,
  input  wire logic [IDX_W-1:0] upd_widx_i,
  input  wire logic [IDX_W-1:0] upd_ridx_i,
  input  wire fill_e            upd_fill_i,
  output logic      [IDX_W-1:0] widx_o,
  output logic      [IDX_W-1:0] ridx_o,
  output fill_e                 fill_o
);

  logic [IDX_W-1:0] widx_q [CHANNELS];
  logic [IDX_W-1:0] ridx_q [CHANNELS];
  fill_e            fill_q [CHANNELS];

  // Look up the selected channel
  assign widx_o = widx_q[ch_i];
  assign ridx_o = ridx_q[ch_i];
  assign fill_o = fill_q[ch_i];

  // Clear on reset, update the selected channel after a move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        widx_q[c] <= '0;
        ridx_q[c] <= '0;
        fill_q[c] <= FILL_EMPTY;
      end
    end else if (upd_en_i) begin
      widx_q[ch_i] <= upd_widx_i;
      ridx_q[ch_i] <= upd_ridx_i;
      fill_q[ch_i] <= upd_fill_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mcrb_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-channel ring buffer port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_ring_buffer_defines.svh"

module mcrb_checker
  import mcrb_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [1:0]        status_code_o,
  input wire logic [DATA_W-1:0] read_data_o,
  input wire logic [SLOT_W-1:0] found_slot_o,
  input wire logic [1:0]        fill_state_o
);

  logic [DATA_W+SLOT_W+3:0] out_word;
  logic                     read_refused;
  logic                     read_word_ok;

  // Gather the result word and its derived checks
  assign out_word     = {status_code_o, read_data_o, found_slot_o, fill_state_o};
  assign read_refused = out_valid_o && (status_code_o == ST_EMPTY_REFUSED);
  assign read_word_ok = (status_code_o == ST_OK) && (found_slot_o == '0) &&
                        (fill_state_o != FILL_FULL);

  // Keep the input open while no word arrives
  `MCRB_ASSERT_NEXT(a_idle_open, !in_stall_o && !in_valid_i, !in_stall_o)

  // Hold a stalled result word
  `MCRB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `MCRB_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))

  // A refused read always reports an empty ring
  `MCRB_ASSERT_NOW(a_refused_read_empty, read_refused, fill_state_o == FILL_EMPTY)

  // Read data only comes with a successful read, never alongside a found slot
  `MCRB_ASSERT_NOW(a_data_only_ok, out_valid_o && (read_data_o != '0), read_word_ok)

endmodule

bind multi_channel_ring_buffer mcrb_checker u_mcrb_checker (.*);

`default_nettype wire
